### src/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants of the polyphonic voice allocator
// Event kinds, the per-voice record, the store command and the sequencer
// states used by the allocator and its voice store.
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

  // Default number of voices.
  localparam int VOICES_DEF = 16;

  // Field widths fixed by the event format.
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int TS_W     = 32;
  localparam int VIN_W    = 4;
  localparam int KIND_W   = 2;
  localparam int VOUT_W   = 4;

  // Stream widths: input word is note, velocity, timestamp, voice_in (50 bits
  // padded to 56); output word is the voice number padded to 8 bits.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;

  // Oldest-voice search starts from the largest timestamp.
  localparam logic [TS_W-1:0] TS_MAX = '1;

  // Event kinds.
  localparam logic [KIND_W-1:0] KIND_ON   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFF  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE = 2'd2;

  // What is kept in memory for each voice.
  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [TS_W-1:0]   ts;
    logic [VEL_W-1:0]  vel;
  } voice_rec_t;

  // Command to the voice store for one cycle.
  typedef struct packed {
    logic wr_rec;   // write note, time and velocity
    logic mk_play;  // mark busy and playing
    logic mk_rel;   // mark releasing
    logic mk_free;  // mark free and idle
  } store_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE,
    ST_FIND,
    ST_LAST_RD,
    ST_SWAP,
    ST_WRITE,
    ST_OFF,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### src/pva_store.sv
// ----------------------------------------------------------------------------
// pva_store: per-voice state store
// Holds note, time and velocity of every voice in a synchronous memory with a
// registered read, and the busy and releasing flags in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_store #(
  parameter int VOICES = pva_pkg::VOICES_DEF,
  localparam int VW = $clog2(VOICES)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pva_pkg::store_op_t op,
  input  wire logic [VW-1:0]      wr_idx,
  input  wire pva_pkg::voice_rec_t wr_rec,
  input  wire logic [VW-1:0]      rd_idx,
  output pva_pkg::voice_rec_t     rd_rec,
  output logic [VOICES-1:0]       busy,
  output logic [VOICES-1:0]       rel
);

  pva_pkg::voice_rec_t rec_mem [VOICES];

  // Record memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (op.wr_rec) begin
      rec_mem[wr_idx] <= wr_rec;
    end
    rd_rec <= rec_mem[rd_idx];
  end

  // Phase flags; a voice is playing when busy and not releasing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      rel  <= '0;
    end else begin
      if (op.mk_play) begin
        busy[wr_idx] <= 1'b1;
        rel[wr_idx]  <= 1'b0;
      end
      if (op.mk_rel) begin
        rel[wr_idx] <= 1'b1;
      end
      if (op.mk_free) begin
        busy[wr_idx] <= 1'b0;
        rel[wr_idx]  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### src/poly_voice_allocator_top.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator_top: polyphonic voice allocator, oldest-voice steal
// A note-on scans the voices for the first free one; if none is free it takes
// the oldest, walks the active list to remove it and then writes it. A
// note-off walks the active list; voice-finished walks it to remove the voice.
// One word is in work at a time; the voice scan and the list walk go one entry
// per cycle through the registered memory ports.
// Reset (synchronous): all voices free and idle, active list empty.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_voice_allocator_top #(
  parameter int VOICES = pva_pkg::VOICES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // note [6:0], velocity [13:7], timestamp [45:14], voice_in [49:46]
  input  wire logic [pva_pkg::IN_TDATA_W-1:0]      s_tdata,
  // kind [1:0]
  input  wire logic [pva_pkg::KIND_W-1:0]          s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // voice [3:0]
  output logic [pva_pkg::OUT_TDATA_W-1:0]          m_tdata,
  // found [0], stolen [1]
  output logic [pva_pkg::OUT_TUSER_W-1:0]          m_tuser
);

  localparam int VW = $clog2(VOICES);
  localparam int CW = $clog2(VOICES + 1);
  // One bit above the wider of the two index widths, so VOICES itself fits.
  localparam int XW = ((VW > pva_pkg::VIN_W) ? VW : pva_pkg::VIN_W) + 1;

  // Input word fields.
  logic [pva_pkg::NOTE_W-1:0] s_note;
  logic [pva_pkg::VEL_W-1:0]  s_vel;
  logic [pva_pkg::TS_W-1:0]   s_ts;
  logic [pva_pkg::VIN_W-1:0]  s_vin;

  assign s_note = s_tdata[6:0];
  assign s_vel  = s_tdata[13:7];
  assign s_ts   = s_tdata[45:14];
  assign s_vin  = s_tdata[49:46];

  pva_pkg::state_t state, state_next;

  // Captured event.
  logic [pva_pkg::KIND_W-1:0] kind_q;
  logic [pva_pkg::NOTE_W-1:0] note_q;
  logic [pva_pkg::VEL_W-1:0]  vel_q;
  logic [pva_pkg::TS_W-1:0]   ts_q;

  // Scan control and pipeline.
  logic [CW-1:0]            count;
  logic [CW-1:0]            idx;
  logic                     a_vld;
  logic [VW-1:0]            a_idx;
  logic                     b_vld;
  logic [VW-1:0]            b_idx;
  logic [VW-1:0]            b_v;
  logic [pva_pkg::TS_W-1:0] best_t;
  logic [VW-1:0]            best;
  logic [VW-1:0]            pick;
  logic [VW-1:0]            pos;

  // Result.
  logic [VW-1:0] res_voice;
  logic          res_found;
  logic          stolen;

  // Active list memory.
  logic [VW-1:0] list_mem [VOICES];
  logic [VW-1:0] list_ra;
  logic [VW-1:0] list_rd;
  logic          list_we;
  logic [VW-1:0] list_wa;
  logic [VW-1:0] list_wd;

  // Voice store interface.
  pva_pkg::store_op_t  st_op;
  logic [VW-1:0]       st_widx;
  pva_pkg::voice_rec_t st_wrec;
  logic [VW-1:0]       st_ridx;
  pva_pkg::voice_rec_t rd_rec;
  logic [VOICES-1:0]   busy;
  logic [VOICES-1:0]   rel;

  // Decoded conditions.
  logic [XW-1:0] vin_x;
  logic          vin_ok;
  logic [VW-1:0] vin_t;
  logic          vin_busy;
  logic          age_free;
  logic          age_upd;
  logic          age_last;
  logic [VW-1:0] age_pick;
  logic          issue_age;
  logic          issue_list;
  logic          find_hit;
  logic          off_hit;
  logic          off_last;
  logic          out_free;

  pva_store #(.VOICES(VOICES)) u_store (
    .clk    (clk),
    .rst    (rst),
    .op     (st_op),
    .wr_idx (st_widx),
    .wr_rec (st_wrec),
    .rd_idx (st_ridx),
    .rd_rec (rd_rec),
    .busy   (busy),
    .rel    (rel)
  );

  // Active list memory with registered read.
  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_wa] <= list_wd;
    end
    list_rd <= list_mem[list_ra];
  end

  // Conditions seen by the sequencer.
  always_comb begin
    vin_x      = XW'(s_vin);
    vin_ok     = vin_x < XW'(VOICES);
    vin_t      = VW'(vin_x);
    vin_busy   = vin_ok && busy[vin_t];
    age_free   = a_vld && !busy[a_idx];
    age_upd    = a_vld && (rd_rec.ts < best_t);
    age_last   = a_vld && (a_idx == VW'(VOICES - 1));
    age_pick   = age_upd ? a_idx : best;
    issue_age  = idx < CW'(VOICES);
    issue_list = idx < count;
    find_hit   = a_vld && (list_rd == pick);
    off_hit    = b_vld && (rd_rec.note == note_q) && busy[b_v] && !rel[b_v];
    off_last   = b_vld && (CW'(b_idx) == count - CW'(1));
    out_free   = !m_tvalid || m_tready;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pva_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser)
            pva_pkg::KIND_ON:   state_next = pva_pkg::ST_AGE;
            pva_pkg::KIND_OFF:  state_next = (count == '0) ? pva_pkg::ST_DONE
                                                           : pva_pkg::ST_OFF;
            pva_pkg::KIND_FREE: state_next = vin_busy ? pva_pkg::ST_FIND
                                                      : pva_pkg::ST_DONE;
            default:            state_next = pva_pkg::ST_DONE;
          endcase
        end
      end
      pva_pkg::ST_AGE: begin
        if (age_free) begin
          state_next = pva_pkg::ST_WRITE;
        end else if (age_last) begin
          state_next = pva_pkg::ST_FIND;
        end
      end
      pva_pkg::ST_FIND: begin
        if (find_hit) begin
          state_next = pva_pkg::ST_LAST_RD;
        end else if (!a_vld && !issue_list) begin
          state_next = pva_pkg::ST_DONE;
        end
      end
      pva_pkg::ST_LAST_RD: state_next = pva_pkg::ST_SWAP;
      pva_pkg::ST_SWAP: begin
        state_next = (kind_q == pva_pkg::KIND_ON) ? pva_pkg::ST_WRITE
                                                  : pva_pkg::ST_DONE;
      end
      pva_pkg::ST_WRITE: state_next = pva_pkg::ST_DONE;
      pva_pkg::ST_OFF: begin
        if (off_hit || off_last) begin
          state_next = pva_pkg::ST_DONE;
        end
      end
      pva_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = pva_pkg::ST_IDLE;
        end
      end
      default: state_next = pva_pkg::ST_IDLE;
    endcase
  end

  // Memory ports and store commands.
  always_comb begin
    s_tready = (state == pva_pkg::ST_IDLE);
    list_ra  = idx[VW-1:0];
    list_we  = 1'b0;
    list_wa  = pos;
    list_wd  = list_rd;
    st_op    = '0;
    st_widx  = pick;
    st_wrec  = '{note: note_q, ts: ts_q, vel: vel_q};
    st_ridx  = list_rd;
    unique case (state)
      pva_pkg::ST_AGE: begin
        st_ridx = idx[VW-1:0];
      end
      pva_pkg::ST_LAST_RD: begin
        list_ra = VW'(count - CW'(1));
      end
      pva_pkg::ST_SWAP: begin
        // The last entry fills the slot of the removed voice.
        list_we = 1'b1;
        if (kind_q != pva_pkg::KIND_ON) begin
          st_op.mk_free = 1'b1;
        end
      end
      pva_pkg::ST_WRITE: begin
        // Append the voice at the end of the list and load its record.
        list_we       = 1'b1;
        list_wa       = count[VW-1:0];
        list_wd       = pick;
        st_op.wr_rec  = 1'b1;
        st_op.mk_play = 1'b1;
      end
      pva_pkg::ST_OFF: begin
        st_widx = b_v;
        if (off_hit) begin
          st_op.mk_rel = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pva_pkg::ST_IDLE;
      count    <= '0;
      idx      <= '0;
      a_vld    <= 1'b0;
      b_vld    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      // Scan pipeline restarts on every state change.
      if (state_next != state) begin
        idx   <= '0;
        a_vld <= 1'b0;
        b_vld <= 1'b0;
      end else if (state == pva_pkg::ST_AGE) begin
        a_vld <= issue_age;
        if (issue_age) begin
          idx <= idx + CW'(1);
        end
      end else if (state == pva_pkg::ST_FIND || state == pva_pkg::ST_OFF) begin
        a_vld <= issue_list;
        b_vld <= a_vld;
        if (issue_list) begin
          idx <= idx + CW'(1);
        end
      end

      if (state == pva_pkg::ST_SWAP) begin
        count <= count - CW'(1);
      end else if (state == pva_pkg::ST_WRITE) begin
        count <= count + CW'(1);
      end

      if (state == pva_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    a_idx <= idx[VW-1:0];
    b_idx <= a_idx;
    b_v   <= list_rd;

    unique case (state)
      pva_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          kind_q    <= s_tuser;
          note_q    <= s_note;
          vel_q     <= s_vel;
          ts_q      <= s_ts;
          pick      <= vin_t;
          best_t    <= pva_pkg::TS_MAX;
          best      <= '0;
          stolen    <= 1'b0;
          res_found <= 1'b0;
          res_voice <= '0;
        end
      end
      pva_pkg::ST_AGE: begin
        // First free voice wins; otherwise track the oldest busy voice.
        if (age_free) begin
          pick <= a_idx;
        end else begin
          if (age_upd) begin
            best_t <= rd_rec.ts;
            best   <= a_idx;
          end
          if (age_last) begin
            pick   <= age_pick;
            stolen <= 1'b1;
          end
        end
      end
      pva_pkg::ST_FIND: begin
        if (find_hit) begin
          pos <= a_idx;
        end
      end
      pva_pkg::ST_SWAP: begin
        if (kind_q != pva_pkg::KIND_ON) begin
          res_voice <= pick;
          res_found <= 1'b1;
        end
      end
      pva_pkg::ST_WRITE: begin
        res_voice <= pick;
        res_found <= 1'b1;
      end
      pva_pkg::ST_OFF: begin
        if (off_hit) begin
          res_voice <= b_v;
          res_found <= 1'b1;
        end
      end
      pva_pkg::ST_DONE: begin
        if (out_free) begin
          m_tdata <= {(pva_pkg::OUT_TDATA_W - pva_pkg::VOUT_W)'(0),
                      pva_pkg::VOUT_W'(res_voice)};
          m_tuser <= {stolen, res_found};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### src/pva_checker.sv
// ----------------------------------------------------------------------------
// pva_checker: port-level checks of the voice allocator
// Watches the stream ports of the top level and flags result words and
// handshake behavior that the allocator must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tvalid,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [pva_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input wire logic [pva_pkg::OUT_TUSER_W-1:0]     m_tuser
);

  // A steal always acts on a voice.
  a_stolen_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] || !m_tuser[1]))
    else $error("stolen word without found");

  // A word that acted on no voice carries voice zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("miss word with nonzero voice");

  // One event in work at a time: input closes right after a word is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after accept");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result word changed while stalled");

endmodule

bind poly_voice_allocator_top pva_checker u_pva_checker (.*);

`default_nettype wire

### sim/poly_voice_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator_top_tb: self-checking bench for the voice allocator
// Drives note-on, note-off and voice-finished words into the slave stream and
// checks every result word against a cycle-free allocation predictor kept in
// the bench. A short directed table comes first, then random traffic under
// several idle and stall patterns, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_voice_allocator_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOICES      = pva_pkg::VOICES_DEF;
  localparam int PAD_W       = pva_pkg::IN_TDATA_W -
                               (pva_pkg::VIN_W + pva_pkg::TS_W + pva_pkg::VEL_W +
                                pva_pkg::NOTE_W);
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  // Kind 3 is not a valid event; the block answers it with an all-zero word.
  localparam logic [pva_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PLAY,
    PH_REL
  } voice_phase_t;

  typedef struct packed {
    logic [pva_pkg::KIND_W-1:0] kind;
    logic [pva_pkg::NOTE_W-1:0] note;
    logic [pva_pkg::VEL_W-1:0]  vel;
    logic [pva_pkg::TS_W-1:0]   ts;
    logic [pva_pkg::VIN_W-1:0]  vin;
  } note_ev_t;

  typedef struct packed {
    logic [pva_pkg::VOUT_W-1:0] voice;
    logic                       found;
    logic                       stolen;
  } alloc_res_t;

  typedef struct {
    note_ev_t   ev;
    bit         typed;
    alloc_res_t res;
  } stim_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [pva_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
  logic [pva_pkg::KIND_W-1:0]       s_tuser = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [pva_pkg::OUT_TDATA_W-1:0]  m_tdata;
  logic [pva_pkg::OUT_TUSER_W-1:0]  m_tuser;

  // Predicted allocator state.
  bit                         pv_busy  [VOICES];
  logic [pva_pkg::NOTE_W-1:0] pv_note  [VOICES];
  logic [pva_pkg::TS_W-1:0]   pv_ts    [VOICES];
  voice_phase_t               pv_phase [VOICES];
  int                         pv_order [VOICES];
  int                         pv_count;

  alloc_res_t alloc_expect_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_on  = 1'b0;

  int fail_count   = 0;
  int result_count = 0;
  int n_alloc      = 0;
  int n_steal      = 0;
  int n_release    = 0;
  int n_freed      = 0;
  int n_noop       = 0;

  poly_voice_allocator_top #(
    .VOICES(VOICES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Remove a voice from the ordered active list by moving the last entry into
  // its slot, and mark it free. Returns 1 if the voice was in the list.
  function automatic bit drop_voice(int v);
    int slot;
    slot = -1;
    for (int i = 0; i < pv_count; i++) begin
      if (slot < 0 && pv_order[i] == v) slot = i;
    end
    if (slot < 0) return 1'b0;
    pv_count--;
    pv_order[slot] = pv_order[pv_count];
    pv_busy[v] = 1'b0;
    return 1'b1;
  endfunction

  // Apply one accepted word to the predicted state and return its result.
  function automatic alloc_res_t alloc_predict(note_ev_t e);
    alloc_res_t                r;
    int                        pick;
    int                        oldest;
    logic [pva_pkg::TS_W-1:0]  oldest_ts;
    bit                        hit;
    int                        v;
    r = '0;
    case (e.kind)
      pva_pkg::KIND_ON: begin
        // Lowest free voice wins; otherwise the oldest, lower index on ties.
        pick = -1;
        oldest = 0;
        oldest_ts = pva_pkg::TS_MAX;
        for (int i = 0; i < VOICES; i++) begin
          if (pick < 0) begin
            if (!pv_busy[i]) pick = i;
            else if (pv_ts[i] < oldest_ts) begin
              oldest_ts = pv_ts[i];
              oldest = i;
            end
          end
        end
        if (pick < 0) begin
          pick = oldest;
          r.stolen = 1'b1;
          void'(drop_voice(pick));
          n_steal++;
        end
        pv_busy[pick]  = 1'b1;
        pv_note[pick]  = e.note;
        pv_ts[pick]    = e.ts;
        pv_phase[pick] = PH_PLAY;
        if (pv_count < VOICES) begin
          pv_order[pv_count] = pick;
          pv_count++;
        end
        r.voice = pva_pkg::VOUT_W'(pick);
        r.found = 1'b1;
        n_alloc++;
      end
      pva_pkg::KIND_OFF: begin
        // First playing voice of this note, in active-list order.
        hit = 1'b0;
        for (int i = 0; i < pv_count; i++) begin
          v = pv_order[i];
          if (!hit && pv_note[v] == e.note && pv_phase[v] == PH_PLAY) begin
            hit = 1'b1;
            pv_phase[v] = PH_REL;
            r.voice = pva_pkg::VOUT_W'(v);
            r.found = 1'b1;
          end
        end
        if (hit) n_release++;
        else n_noop++;
      end
      pva_pkg::KIND_FREE: begin
        // A listed voice is freed whatever its phase.
        if (drop_voice(int'(e.vin))) begin
          pv_phase[e.vin] = PH_IDLE;
          r.voice = e.vin;
          r.found = 1'b1;
          n_freed++;
        end else begin
          n_noop++;
        end
      end
      default: n_noop++;
    endcase
    return r;
  endfunction

  function automatic stim_row_t row(logic [pva_pkg::KIND_W-1:0] kind, int note, int vel,
                                    logic [pva_pkg::TS_W-1:0] ts, int vin, bit typed,
                                    int voice, bit found, bit stolen);
    stim_row_t s;
    s.ev.kind = kind;
    s.ev.note = pva_pkg::NOTE_W'(note);
    s.ev.vel  = pva_pkg::VEL_W'(vel);
    s.ev.ts   = ts;
    s.ev.vin  = pva_pkg::VIN_W'(vin);
    s.typed   = typed;
    s.res.voice  = pva_pkg::VOUT_W'(voice);
    s.res.found  = found;
    s.res.stolen = stolen;
    return s;
  endfunction

  // Random word, biased toward events that act on voices that are in use.
  function automatic note_ev_t rand_event();
    note_ev_t    e;
    int unsigned pick;
    e.kind = KIND_NONE;
    e.note = pva_pkg::NOTE_W'($urandom_range(127));
    e.vel  = pva_pkg::VEL_W'($urandom_range(127));
    e.ts   = $urandom;
    e.vin  = pva_pkg::VIN_W'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 45) begin
      e.kind = pva_pkg::KIND_ON;
      // A narrow note pool gives several voices on the same note.
      if ($urandom_range(1) != 0) e.note = pva_pkg::NOTE_W'(60 + $urandom_range(7));
      // Small and near-maximum times give ties for the steal search.
      case ($urandom_range(3))
        0: e.ts = pva_pkg::TS_W'($urandom_range(7));
        1: e.ts = pva_pkg::TS_MAX - pva_pkg::TS_W'($urandom_range(3));
        default: ;
      endcase
    end else if (pick < 70) begin
      e.kind = pva_pkg::KIND_OFF;
      if (pv_count != 0 && $urandom_range(99) < 85)
        e.note = pv_note[pv_order[$urandom_range(pv_count - 1)]];
    end else if (pick < 95) begin
      e.kind = pva_pkg::KIND_FREE;
      if (pv_count != 0 && $urandom_range(99) < 85)
        e.vin = pva_pkg::VIN_W'(pv_order[$urandom_range(pv_count - 1)]);
    end
    return e;
  endfunction

  // Offer one word, wait for it to be taken and queue its expected result.
  task automatic send_word(input note_ev_t e, input bit typed, input alloc_res_t typed_res);
    alloc_res_t r;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, e.vin, e.ts, e.vel, e.note};
    s_tuser  <= e.kind;
    do @(posedge clk); while (!s_tready);
    r = alloc_predict(e);
    alloc_expect_q.push_back(typed ? typed_res : r);
  endtask

  // Random traffic under one idle/stall setting, then wait for a full drain.
  task automatic run_phase(int n, int unsigned idle, int unsigned stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) send_word(rand_event(), 1'b0, '0);
    s_tvalid <= 1'b0;
    while (alloc_expect_q.size() != 0) @(posedge clk);
  endtask

  // Receiver ready, with random stalls and the long hold-off.
  always @(posedge clk) begin
    m_tready <= !rst && !hold_on && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin : hold_off
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Compare each accepted result word with the oldest pending prediction.
  always @(posedge clk) begin : result_check
    alloc_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (alloc_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result word tdata=%h tuser=%b",
                   $realtime, m_tdata, m_tuser);
      end else begin
        want = alloc_expect_q.pop_front();
        result_count++;
        if (m_tdata !== {{(pva_pkg::OUT_TDATA_W - pva_pkg::VOUT_W){1'b0}}, want.voice} ||
            m_tuser[0] !== want.found || m_tuser[1] !== want.stolen) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result %0d mismatch: voice %0d/%0d found %b/%b %s %b/%b %s",
                     $realtime, result_count, want.voice, m_tdata, want.found,
                     m_tuser[0], "stolen", want.stolen, m_tuser[1], "(exp/got)");
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    stim_row_t rows[$];
    pv_count = 0;
    for (int v = 0; v < VOICES; v++) begin
      pv_busy[v]  = 1'b0;
      pv_note[v]  = '0;
      pv_ts[v]    = '0;
      pv_phase[v] = PH_IDLE;
      pv_order[v] = 0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: empty-pool misses, unknown kind, a full pool at maximum
    // time, the all-maximum steal, then release and free on a full pool.
    rows.push_back(row(pva_pkg::KIND_OFF, 60, 0, '0, 0, 1'b1, 0, 1'b0, 1'b0));
    rows.push_back(row(pva_pkg::KIND_FREE, 0, 0, '0, 5, 1'b1, 0, 1'b0, 1'b0));
    rows.push_back(row(KIND_NONE, 127, 127, pva_pkg::TS_MAX, 15, 1'b1, 0, 1'b0, 1'b0));
    for (int v = 0; v < VOICES; v++)
      rows.push_back(row(pva_pkg::KIND_ON, (v == 1) ? 127 : v, (v == 1) ? 127 : v,
                         pva_pkg::TS_MAX, v, 1'b1, v, 1'b1, 1'b0));
    rows.push_back(row(pva_pkg::KIND_ON, 64, 127, '0, 0, 1'b1, 0, 1'b1, 1'b1));
    rows.push_back(row(pva_pkg::KIND_OFF, 127, 0, '0, 0, 1'b0, 0, 1'b0, 1'b0));
    rows.push_back(row(pva_pkg::KIND_OFF, 127, 0, '0, 0, 1'b0, 0, 1'b0, 1'b0));
    rows.push_back(row(pva_pkg::KIND_FREE, 0, 0, '0, 1, 1'b0, 0, 1'b0, 1'b0));
    rows.push_back(row(pva_pkg::KIND_FREE, 0, 0, '0, 2, 1'b0, 0, 1'b0, 1'b0));
    rows.push_back(row(pva_pkg::KIND_ON, 0, 0, 32'h8000_0000, 0, 1'b0, 0, 1'b0, 1'b0));
    foreach (rows[k]) send_word(rows[k].ev, rows[k].typed, rows[k].res);
    s_tvalid <= 1'b0;
    while (alloc_expect_q.size() != 0) @(posedge clk);

    // Random traffic: free running, idle sender, stalling receiver, both.
    run_phase(280, 0, 0);
    run_phase(260, 63, 0);
    run_phase(260, 0, 63);
    run_phase(260, 14, 14);

    // Receiver holds off while the sender keeps offering words.
    hold_req <= 1'b1;
    run_phase(240, 0, 0);

    repeat (2 * VOICES + 10) @(posedge clk);

    $display("Checked %0d result words: %0d allocations (%0d by stealing), %0d releases,",
             result_count, n_alloc, n_steal, n_release);
    $display("%0d voices freed and %0d events with no effect, %0d mismatches.",
             n_freed, n_noop, fail_count);
    if (fail_count == 0 && alloc_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/pva_pkg.sv
src/pva_store.sv
src/poly_voice_allocator_top.sv
src/pva_checker.sv
sim/poly_voice_allocator_top_tb.sv
